// File: hw/rtl/ffa_pkg.sv
// Shared types, constants and microcode encodings for the first-fit block allocator.
package ffa_pkg;

  localparam int POOL_WORDS = 1024;
  localparam int WORD_BYTES = 8;
  localparam int WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int ADDR_W     = $clog2(POOL_WORDS);
  localparam int IDX_W      = ADDR_W + 2;
  localparam int HDR_W      = 15;
  localparam int PC_W       = 5;

  localparam int OP_W    = 2;
  localparam int REQ_W   = 14;
  localparam int OFF_W   = 13;
  localparam int STAT_W  = 2;
  localparam int LARGE_W = 14;

  typedef logic [PC_W-1:0]         pc_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [HDR_W-1:0]        mag_t;
  typedef logic signed [HDR_W-1:0] hdr_t;

  localparam idx_t POOL_IDX = idx_t'(POOL_WORDS);
  localparam mag_t POOL_CAP = mag_t'(POOL_WORDS * WORD_BYTES);
  localparam mag_t MIN_POOL = mag_t'(2 * WORD_BYTES);
  localparam mag_t WORD_B   = mag_t'(WORD_BYTES);
  localparam mag_t ROUND_B  = mag_t'(WORD_BYTES - 1);
  localparam logic [REQ_W-1:0] POOL_BYTES_RST = REQ_W'(POOL_WORDS * WORD_BYTES);

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FAIL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SMALL = 2'd2;

  typedef enum logic [3:0] {
    U_NONE,
    U_ACCEPT,
    U_INIT0,
    U_INIT1,
    U_RD_I,
    U_RD_J,
    U_LOAD_SZ,
    U_MERGE,
    U_I_FROM_SZ,
    U_FIT,
    U_SPLIT,
    U_STEP_I,
    U_FREE,
    U_QEND,
    U_QACC,
    U_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_NO_ITEM,
    C_SMALL,
    C_H_ZERO,
    C_H_POS,
    C_H_NOT_NEG,
    C_H_NOT_POS,
    C_SZ_GE_REQ,
    C_NO_SPLIT,
    C_PAY_GT,
    C_PAY_NE,
    C_OUT_BUSY
  } cond_t;

  // microcode step addresses
  localparam pc_t P_IDLE  = 5'd0;
  localparam pc_t P_DISP  = 5'd1;
  localparam pc_t P_INIT  = 5'd2;
  localparam pc_t P_INIT1 = 5'd3;
  localparam pc_t P_AREAD = 5'd4;
  localparam pc_t P_AZERO = 5'd5;
  localparam pc_t P_AFREE = 5'd6;
  localparam pc_t P_AFIT  = 5'd7;
  localparam pc_t P_MREAD = 5'd8;
  localparam pc_t P_MCHK  = 5'd9;
  localparam pc_t P_MERGE = 5'd10;
  localparam pc_t P_MEND  = 5'd11;
  localparam pc_t P_ANEXT = 5'd12;
  localparam pc_t P_FIT   = 5'd13;
  localparam pc_t P_SPLIT = 5'd14;
  localparam pc_t P_FREAD = 5'd15;
  localparam pc_t P_FZERO = 5'd16;
  localparam pc_t P_FPAST = 5'd17;
  localparam pc_t P_FMATCH = 5'd18;
  localparam pc_t P_FUSED = 5'd19;
  localparam pc_t P_FMARK = 5'd20;
  localparam pc_t P_FSTEP = 5'd21;
  localparam pc_t P_QREAD = 5'd22;
  localparam pc_t P_QZERO = 5'd23;
  localparam pc_t P_QACC  = 5'd24;
  localparam pc_t P_DONE  = 5'd25;
  localparam pc_t P_EMIT  = 5'd26;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic item;
    logic undersized;
    logic h_zero;
    logic h_pos;
    logic h_neg;
    logic sz_ge_req;
    logic no_split;
    logic pay_gt;
    logic pay_ne;
    logic out_busy;
    pc_t  disp;
  } flags_t;

endpackage

// File: hw/rtl/ffa_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
module ffa_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  ffa_pkg::flags_t flags,
  output ffa_pkg::ctrl_t  ctrl
);
  import ffa_pkg::*;

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic take;

  always_comb begin
    unique case (pc_r)
      P_IDLE:   ctrl = '{U_ACCEPT,    C_NO_ITEM,   P_IDLE};
      P_DISP:   ctrl = '{U_NONE,      C_DISPATCH,  P_IDLE};
      P_INIT:   ctrl = '{U_INIT0,     C_SMALL,     P_DONE};
      P_INIT1:  ctrl = '{U_INIT1,     C_ALWAYS,    P_DONE};
      P_AREAD:  ctrl = '{U_RD_I,      C_NEVER,     P_IDLE};
      P_AZERO:  ctrl = '{U_NONE,      C_H_ZERO,    P_DONE};
      P_AFREE:  ctrl = '{U_LOAD_SZ,   C_H_POS,     P_ANEXT};
      P_AFIT:   ctrl = '{U_NONE,      C_SZ_GE_REQ, P_FIT};
      P_MREAD:  ctrl = '{U_RD_J,      C_NEVER,     P_IDLE};
      P_MCHK:   ctrl = '{U_NONE,      C_H_NOT_NEG, P_MEND};
      P_MERGE:  ctrl = '{U_MERGE,     C_ALWAYS,    P_MREAD};
      P_MEND:   ctrl = '{U_NONE,      C_SZ_GE_REQ, P_FIT};
      P_ANEXT:  ctrl = '{U_I_FROM_SZ, C_ALWAYS,    P_AREAD};
      P_FIT:    ctrl = '{U_FIT,       C_NO_SPLIT,  P_DONE};
      P_SPLIT:  ctrl = '{U_SPLIT,     C_ALWAYS,    P_DONE};
      P_FREAD:  ctrl = '{U_RD_I,      C_NEVER,     P_IDLE};
      P_FZERO:  ctrl = '{U_NONE,      C_H_ZERO,    P_DONE};
      P_FPAST:  ctrl = '{U_NONE,      C_PAY_GT,    P_DONE};
      P_FMATCH: ctrl = '{U_NONE,      C_PAY_NE,    P_FSTEP};
      P_FUSED:  ctrl = '{U_NONE,      C_H_NOT_POS, P_DONE};
      P_FMARK:  ctrl = '{U_FREE,      C_ALWAYS,    P_DONE};
      P_FSTEP:  ctrl = '{U_STEP_I,    C_ALWAYS,    P_FREAD};
      P_QREAD:  ctrl = '{U_RD_I,      C_NEVER,     P_IDLE};
      P_QZERO:  ctrl = '{U_QEND,      C_H_ZERO,    P_DONE};
      P_QACC:   ctrl = '{U_QACC,      C_ALWAYS,    P_QREAD};
      P_DONE:   ctrl = '{U_NONE,      C_OUT_BUSY,  P_DONE};
      P_EMIT:   ctrl = '{U_EMIT,      C_ALWAYS,    P_IDLE};
      default:  ctrl = '{U_NONE,      C_ALWAYS,    P_IDLE};
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_DISPATCH:  take = 1'b1;
      C_NO_ITEM:   take = !flags.item;
      C_SMALL:     take = flags.undersized;
      C_H_ZERO:    take = flags.h_zero;
      C_H_POS:     take = flags.h_pos;
      C_H_NOT_NEG: take = !flags.h_neg;
      C_H_NOT_POS: take = !flags.h_pos;
      C_SZ_GE_REQ: take = flags.sz_ge_req;
      C_NO_SPLIT:  take = flags.no_split;
      C_PAY_GT:    take = flags.pay_gt;
      C_PAY_NE:    take = flags.pay_ne;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b0;
    endcase
    priority if (ctrl.cond == C_DISPATCH) begin
      pc_nxt = flags.disp;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: hw/rtl/first_fit_variable_block_allocator.sv
// Top level: first-fit boundary-tag allocator, header memory and datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_op, in_request_bytes, in_payload_offset
//   out      output     out_valid/out_ready  out_status, out_block_offset, out_largest_free
//   cfg      input      cfg_wr_en            cfg_wr_data (pool size in bytes)
//
// One item at a time: alloc, free and query walk the headers one by one, and an alloc
// merge check may absorb further free blocks; init writes the first and last headers.
// Every header is read through the one registered read port of the header memory.
// Reset clears control only; the pool is unusable until an init item.
// A finished result waits in the output register; the next item may be taken
// meanwhile but holds in its last step until the output is free.
module first_fit_variable_block_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ffa_pkg::REQ_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ffa_pkg::OP_W-1:0]    in_op,
  input  logic [ffa_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]   in_payload_offset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffa_pkg::STAT_W-1:0]  out_status,
  output logic [ffa_pkg::OFF_W-1:0]   out_block_offset,
  output logic [ffa_pkg::LARGE_W-1:0] out_largest_free
);
  import ffa_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  hdr_t hdr_mem [POOL_WORDS];
  hdr_t rd_data_r;
  logic rd_oob_r;
  logic mem_we;
  idx_t mem_waddr;
  hdr_t mem_wdata;
  logic mem_re;
  idx_t mem_raddr;

  logic [REQ_W-1:0]   pool_bytes_r,   pool_bytes_nxt;
  logic               pool_ready_r,   pool_ready_nxt;
  logic [OP_W-1:0]    op_r,           op_nxt;
  mag_t               req_r,          req_nxt;
  logic [OFF_W-1:0]   off_r,          off_nxt;
  idx_t               i_r,            i_nxt;
  idx_t               j_r,            j_nxt;
  mag_t               sz_r,           sz_nxt;
  mag_t               cur_r,          cur_nxt;
  mag_t               best_r,         best_nxt;
  logic [STAT_W-1:0]  status_r,       status_nxt;
  logic [OFF_W-1:0]   offset_r,       offset_nxt;
  logic [LARGE_W-1:0] largest_r,      largest_nxt;
  logic               out_valid_r,    out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r,   out_status_nxt;
  logic [OFF_W-1:0]   out_offset_r,   out_offset_nxt;
  logic [LARGE_W-1:0] out_largest_r,  out_largest_nxt;

  hdr_t                       hv;
  mag_t                       hmag;
  idx_t                       hword;
  idx_t                       i_inc;
  idx_t                       next_i;
  idx_t                       next_j;
  idx_t                       i_after_sz;
  mag_t                       sz_merged;
  idx_t                       split_idx;
  mag_t                       rem;
  mag_t                       rest;
  mag_t                       req_sum;
  mag_t                       req_round;
  mag_t                       pool_sum;
  mag_t                       pool_round;
  mag_t                       pool_eff;
  logic                       pool_small;
  idx_t                       end_idx;
  logic [IDX_W+WORD_SHIFT-1:0] pay;
  mag_t                       run_max;
  logic                       emit;

  assign in_ready         = (ctrl.uop == U_ACCEPT);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_offset_r;
  assign out_largest_free = out_largest_r;

  ffa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // header memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we && (mem_waddr < POOL_IDX)) begin
      hdr_mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= hdr_mem[mem_raddr[ADDR_W-1:0]];
      rd_oob_r  <= (mem_raddr >= POOL_IDX);
    end
  end

  always_comb begin
    hv         = rd_oob_r ? hdr_t'(0) : rd_data_r;
    hmag       = hv[HDR_W-1] ? mag_t'(-hv) : mag_t'(hv);
    hword      = idx_t'(hmag >> WORD_SHIFT);
    i_inc      = i_r + idx_t'(1);
    next_i     = i_inc + hword;
    next_j     = j_r + idx_t'(1) + hword;
    i_after_sz = i_inc + idx_t'(sz_r >> WORD_SHIFT);
    sz_merged  = sz_r + hmag + WORD_B;
    split_idx  = i_inc + idx_t'(req_r >> WORD_SHIFT);
    rem        = sz_r - req_r;
    rest       = rem - WORD_B;
    req_sum    = mag_t'(in_request_bytes) + ROUND_B;
    req_round  = {req_sum[HDR_W-1:WORD_SHIFT], {WORD_SHIFT{1'b0}}};
    pool_sum   = mag_t'(pool_bytes_r) + ROUND_B;
    pool_round = {pool_sum[HDR_W-1:WORD_SHIFT], {WORD_SHIFT{1'b0}}};
    pool_eff   = (pool_round > POOL_CAP) ? POOL_CAP : pool_round;
    pool_small = (pool_eff < MIN_POOL);
    end_idx    = idx_t'(pool_eff >> WORD_SHIFT) - idx_t'(1);
    pay        = {i_inc, {WORD_SHIFT{1'b0}}};
    run_max    = (cur_r > best_r) ? cur_r : best_r;
  end

  always_comb begin
    flags.item       = in_valid;
    flags.undersized = pool_small;
    flags.h_zero     = (hv == hdr_t'(0));
    flags.h_pos      = !hv[HDR_W-1] && (hv != hdr_t'(0));
    flags.h_neg      = hv[HDR_W-1];
    flags.sz_ge_req  = (sz_r >= req_r);
    flags.no_split   = (rem < MIN_POOL);
    flags.pay_gt     = (pay > (IDX_W+WORD_SHIFT)'(off_r));
    flags.pay_ne     = (pay != (IDX_W+WORD_SHIFT)'(off_r));
    flags.out_busy   = out_valid_r && !out_ready;
    priority if (op_r == OP_INIT) begin
      flags.disp = P_INIT;
    end else if (!pool_ready_r) begin
      flags.disp = P_DONE;
    end else if (op_r == OP_ALLOC) begin
      flags.disp = (req_r == mag_t'(0)) ? P_DONE : P_AREAD;
    end else if (op_r == OP_FREE) begin
      flags.disp = P_FREAD;
    end else begin
      flags.disp = P_QREAD;
    end
  end

  always_comb begin
    pool_bytes_nxt = cfg_wr_en ? cfg_wr_data : pool_bytes_r;
    pool_ready_nxt = pool_ready_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    off_nxt        = off_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    sz_nxt         = sz_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    status_nxt     = status_r;
    offset_nxt     = offset_r;
    largest_nxt    = largest_r;
    mem_we         = 1'b0;
    mem_waddr      = i_r;
    mem_wdata      = hdr_t'(0);
    mem_re         = 1'b0;
    mem_raddr      = i_r;
    emit           = 1'b0;
    unique case (ctrl.uop)
      U_ACCEPT: begin
        if (in_valid) begin
          op_nxt      = in_op;
          req_nxt     = req_round;
          off_nxt     = in_payload_offset;
          i_nxt       = idx_t'(0);
          cur_nxt     = mag_t'(0);
          best_nxt    = mag_t'(0);
          status_nxt  = STAT_FAIL;
          offset_nxt  = '0;
          largest_nxt = '0;
        end
      end
      U_INIT0: begin
        status_nxt     = pool_small ? STAT_SMALL : STAT_OK;
        pool_ready_nxt = !pool_small;
        mem_we         = !pool_small;
        mem_waddr      = idx_t'(0);
        mem_wdata      = $signed(-(pool_eff - MIN_POOL));
      end
      U_INIT1: begin
        mem_we    = 1'b1;
        mem_waddr = end_idx;
        mem_wdata = hdr_t'(0);
      end
      U_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
      end
      U_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = j_r;
      end
      U_LOAD_SZ: begin
        sz_nxt = hmag;
        j_nxt  = next_i;
      end
      U_MERGE: begin
        sz_nxt    = sz_merged;
        j_nxt     = next_j;
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = $signed(-sz_merged);
      end
      U_I_FROM_SZ: begin
        i_nxt = i_after_sz;
      end
      U_FIT: begin
        status_nxt = STAT_OK;
        offset_nxt = OFF_W'(pay);
        mem_we     = 1'b1;
        mem_waddr  = i_r;
        mem_wdata  = flags.no_split ? $signed(sz_r) : $signed(req_r);
      end
      U_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = split_idx;
        mem_wdata = $signed(-rest);
      end
      U_STEP_I: begin
        i_nxt = next_i;
      end
      U_FREE: begin
        status_nxt = STAT_OK;
        mem_we     = 1'b1;
        mem_waddr  = i_r;
        mem_wdata  = -hv;
      end
      U_QEND: begin
        status_nxt  = STAT_OK;
        largest_nxt = run_max[LARGE_W-1:0];
      end
      U_QACC: begin
        i_nxt = next_i;
        if (flags.h_pos) begin
          best_nxt = run_max;
          cur_nxt  = mag_t'(0);
        end else begin
          cur_nxt = cur_r + hmag;
        end
      end
      U_EMIT: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_offset_nxt  = out_offset_r;
    out_largest_nxt = out_largest_r;
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = status_r;
      out_offset_nxt  = offset_r;
      out_largest_nxt = largest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_bytes_r <= POOL_BYTES_RST;
      pool_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pool_bytes_r <= pool_bytes_nxt;
      pool_ready_r <= pool_ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    req_r         <= req_nxt;
    off_r         <= off_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    sz_r          <= sz_nxt;
    cur_r         <= cur_nxt;
    best_r        <= best_nxt;
    status_r      <= status_nxt;
    offset_r      <= offset_nxt;
    largest_r     <= largest_nxt;
    out_status_r  <= out_status_nxt;
    out_offset_r  <= out_offset_nxt;
    out_largest_r <= out_largest_nxt;
  end

  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.uop == U_EMIT) |-> !out_valid_r)
    else $error("result emitted over a pending item");

  a_ready_by_init: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pool_ready_r) |-> $past(ctrl.uop == U_INIT0))
    else $error("pool became ready outside init");

  a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_offset_r[WORD_SHIFT-1:0] == '0))
    else $error("payload offset not word aligned");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |->
      ((out_offset_r == '0) && (out_largest_r == '0)))
    else $error("failed item carries nonzero payload");

endmodule
